// ===== design/qsdi_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qsdi_pkg
// Shared types and constants for the ordered store with search, delete and
// positional insert.
// ----------------------------------------------------------------------------
package qsdi_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int DATA_W    = 32;
    localparam int CNT_W     = 7;

    typedef enum logic [2:0] {
        ACT_APPEND = 3'd0,
        ACT_SEARCH = 3'd1,
        ACT_DELETE = 3'd2,
        ACT_INSERT = 3'd3,
        ACT_DUMP   = 3'd4
    } action_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctl_t;

endpackage : qsdi_pkg
`default_nettype wire

// ===== design/qsdi_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qsdi_cell
// One entry of the store: takes the neighbor's entry on a shift, or the
// write bus on a load (load wins).
// ----------------------------------------------------------------------------
module qsdi_cell
    import qsdi_pkg::*;
(
    input  wire logic                     clk,
    input  wire cell_ctl_t                ctl,
    input  wire logic signed [DATA_W-1:0] nbr,
    input  wire logic signed [DATA_W-1:0] wr_data,
    output logic signed [DATA_W-1:0]      q
);

    logic signed [DATA_W-1:0] q_reg;
    logic signed [DATA_W-1:0] q_next;

    always_comb
    begin
        q_next = q_reg;
        if (ctl.load)
        begin
            q_next = wr_data;
        end
        else if (ctl.shift)
        begin
            q_next = nbr;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule : qsdi_cell
`default_nettype wire

// ===== design/queue_search_delete_insert_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// queue_search_delete_insert_engine
// Ordered store of signed 32-bit values held in a chain of cells, with
// append, search, delete-all-equal, positional insert and dump.
// ----------------------------------------------------------------------------
// One request at a time. Append, an insert that appends or finds the store
// full, and unused action codes are accepted and then finished by one step.
// Search, delete and dump rotate the chain once: the head is examined and
// written back at the tail (delete drops matches), one entry per cycle,
// save that steps that produce a result wait while the output register is
// still held by the consumer. A positional insert rotates the entries ahead
// of the slot, drops the value in at the tail and rotates the rest.
// ----------------------------------------------------------------------------
module queue_search_delete_insert_engine
    import qsdi_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [2:0]               action,
    input  wire logic signed [DATA_W-1:0] value,
    input  wire logic [CNT_W-1:0]         position,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [1:0]                    status,
    output logic                          found,
    output logic [CNT_W-1:0]              removed,
    output logic signed [DATA_W-1:0]      data,
    output logic [CNT_W-1:0]              occupancy,
    output logic                          last
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } state_t;

    state_t                   state_reg, state_next;
    logic [2:0]               act_reg;
    logic signed [DATA_W-1:0] val_reg;
    logic [CNT_W-1:0]         pos_reg;
    logic [CW-1:0]            fill_reg, fill_next;
    logic [CW-1:0]            start_reg;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic                     hit_reg, hit_next;
    logic [CW-1:0]            rem_reg, rem_next;

    logic                     out_valid_reg, out_valid_next;
    logic [1:0]               status_reg;
    logic                     found_reg;
    logic [CNT_W-1:0]         removed_reg;
    logic signed [DATA_W-1:0] data_reg;
    logic [CNT_W-1:0]         occ_reg;
    logic                     last_reg;

    logic signed [DATA_W-1:0] cell_q [DEPTH];
    cell_ctl_t                ctl    [DEPTH];

    logic                     accept;
    logic                     can_emit;
    logic                     emit;
    logic                     step_go;
    logic                     done;
    logic                     shift_en;
    logic                     wr_en;
    logic [IW-1:0]            wr_idx;
    logic signed [DATA_W-1:0] wr_data;
    logic [1:0]               e_status;
    logic                     e_found;
    logic [CW-1:0]            e_removed;
    logic signed [DATA_W-1:0] e_data;
    logic                     e_last;
    logic                     full;
    logic                     empty;
    logic                     match;
    logic                     last_step;
    logic                     walk_ins;
    logic                     at_slot;
    logic [IW-1:0]            tail_idx;
    logic [IW-1:0]            free_idx;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign can_emit = !out_valid_reg || out_ready;

    assign full      = (start_reg == CW'(DEPTH));
    assign empty     = (start_reg == '0);
    assign match     = (cell_q[0] == val_reg);
    assign last_step = (cnt_reg == start_reg - CW'(1));
    assign walk_ins  = (pos_reg != '0) && (pos_reg <= CNT_W'(fill_reg));
    assign at_slot   = (CNT_W'(cnt_reg) == pos_reg - CNT_W'(1));
    assign tail_idx  = IW'(fill_reg - CW'(1));
    assign free_idx  = IW'(fill_reg);

    always_comb
    begin
        emit      = 1'b0;
        done      = 1'b0;
        shift_en  = 1'b0;
        wr_en     = 1'b0;
        wr_idx    = free_idx;
        wr_data   = val_reg;
        fill_next = fill_reg;
        hit_next  = hit_reg;
        rem_next  = rem_reg;
        e_status  = ST_OK;
        e_found   = 1'b0;
        e_removed = '0;
        e_data    = '0;
        e_last    = 1'b1;

        case (act_reg)
            ACT_APPEND:
            begin
                emit = 1'b1;
                done = 1'b1;
                if (full)
                begin
                    e_status = ST_FULL;
                end
                else
                begin
                    wr_en     = 1'b1;
                    fill_next = fill_reg + CW'(1);
                end
            end
            ACT_SEARCH:
            begin
                if (empty)
                begin
                    emit = 1'b1;
                    done = 1'b1;
                end
                else
                begin
                    shift_en = 1'b1;
                    wr_en    = 1'b1;
                    wr_idx   = tail_idx;
                    wr_data  = cell_q[0];
                    hit_next = hit_reg || match;
                    if (last_step)
                    begin
                        emit    = 1'b1;
                        done    = 1'b1;
                        e_found = hit_next;
                    end
                end
            end
            ACT_DELETE:
            begin
                if (empty)
                begin
                    emit = 1'b1;
                    done = 1'b1;
                end
                else
                begin
                    shift_en = 1'b1;
                    if (match)
                    begin
                        fill_next = fill_reg - CW'(1);
                        rem_next  = rem_reg + CW'(1);
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_idx  = tail_idx;
                        wr_data = cell_q[0];
                    end
                    if (last_step)
                    begin
                        emit      = 1'b1;
                        done      = 1'b1;
                        e_removed = rem_next;
                    end
                end
            end
            ACT_INSERT:
            begin
                if (full)
                begin
                    emit     = 1'b1;
                    done     = 1'b1;
                    e_status = ST_FULL;
                end
                else if (!walk_ins)
                begin
                    emit      = 1'b1;
                    done      = 1'b1;
                    wr_en     = 1'b1;
                    fill_next = fill_reg + CW'(1);
                end
                else if (at_slot)
                begin
                    wr_en     = 1'b1;
                    fill_next = fill_reg + CW'(1);
                end
                else
                begin
                    shift_en = 1'b1;
                    wr_en    = 1'b1;
                    wr_idx   = tail_idx;
                    wr_data  = cell_q[0];
                    if (cnt_reg == start_reg)
                    begin
                        emit = 1'b1;
                        done = 1'b1;
                    end
                end
            end
            ACT_DUMP:
            begin
                if (empty)
                begin
                    emit     = 1'b1;
                    done     = 1'b1;
                    e_status = ST_EMPTY;
                end
                else
                begin
                    shift_en = 1'b1;
                    wr_en    = 1'b1;
                    wr_idx   = tail_idx;
                    wr_data  = cell_q[0];
                    emit     = 1'b1;
                    e_data   = cell_q[0];
                    e_last   = last_step;
                    done     = last_step;
                end
            end
            default:
            begin
                emit = 1'b1;
                done = 1'b1;
            end
        endcase
    end

    assign step_go  = (state_reg == S_RUN) && (!emit || can_emit);
    assign cnt_next = cnt_reg + CW'(1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (step_go && done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (step_go && emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (step_go)
            begin
                fill_reg <= fill_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg   <= action;
            val_reg   <= value;
            pos_reg   <= position;
            start_reg <= fill_reg;
            cnt_reg   <= '0;
            hit_reg   <= 1'b0;
            rem_reg   <= '0;
        end
        else if (step_go)
        begin
            cnt_reg <= cnt_next;
            hit_reg <= hit_next;
            rem_reg <= rem_next;
        end
        if (step_go && emit)
        begin
            status_reg  <= e_status;
            found_reg   <= e_found;
            removed_reg <= CNT_W'(e_removed);
            data_reg    <= e_data;
            occ_reg     <= CNT_W'(fill_next);
            last_reg    <= e_last;
        end
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] nbr;

        if (i == DEPTH - 1)
        begin : g_end
            assign nbr = wr_data;
        end
        else
        begin : g_mid
            assign nbr = cell_q[i+1];
        end

        assign ctl[i].shift = step_go && shift_en;
        assign ctl[i].load  = step_go && wr_en && (wr_idx == IW'(i));

        qsdi_cell u_cell (
            .clk     (clk),
            .ctl     (ctl[i]),
            .nbr     (nbr),
            .wr_data (wr_data),
            .q       (cell_q[i])
        );
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign found     = found_reg;
    assign removed   = removed_reg;
    assign data      = data_reg;
    assign occupancy = occ_reg;
    assign last      = last_reg;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(DEPTH))
        else $error("fill count beyond depth");

    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |=> $stable(fill_reg))
        else $error("fill changed with no request in progress");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (step_go && emit && e_last) |=> (state_reg == S_IDLE))
        else $error("final result emitted but request still running");

    a_del_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_RUN) && (act_reg == ACT_DELETE)) |=>
        (fill_reg <= $past(fill_reg)))
        else $error("delete grew the store");
`endif

endmodule : queue_search_delete_insert_engine
`default_nettype wire
